// File: hdl/cht_pkg.sv
// Package for the chained hash table: opcodes, status codes, front and back state types.
// No dependencies.
`default_nettype none
package cht_pkg;
    localparam int BUCKETS_DEF    = 11;
    localparam int POOL_NODES_DEF = 64;
    localparam int KEY_W          = 31;
    localparam int BKT_W          = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Remainder unit state and back-end state.
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD,
        BK_READ,
        BK_CMP,
        BK_UNLINK,
        BK_DONE
    } back_state_t;
endpackage
`default_nettype wire

// File: hdl/cht_front.sv
// Front end: accepts items and computes key mod BUCKETS by reciprocal multiply.
// Depends on cht_pkg.
`default_nettype none
module cht_front import cht_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int HB_W    = $clog2(BUCKETS)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [KEY_W-1:0] in_key,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output logic [1:0]            q_op,
    output logic [KEY_W-1:0]      q_key,
    output logic [HB_W-1:0]       q_bucket
);
    // floor(2^KEY_W / BUCKETS): the quotient estimate is low by at most one
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);
    localparam logic [KEY_W-1:0] BKT_K = KEY_W'(BUCKETS);
    localparam logic [HB_W:0]    BKT   = (HB_W + 1)'(BUCKETS);

    front_state_t       state_reg, state_next;
    logic [2*KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0]   quot;
    logic [KEY_W-1:0]   diff;
    logic [HB_W:0]      rem_reg;
    logic [HB_W:0]      rem_fix;
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;

    assign quot    = prod_reg[2*KEY_W-1:KEY_W];
    assign diff    = key_reg - quot * BKT_K;
    assign rem_fix = (rem_reg >= BKT) ? rem_reg - BKT : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (in_valid && in_ready) begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        if (state_reg == FR_MUL) begin
            prod_reg <= (2*KEY_W)'(key_reg) * (2*KEY_W)'(RECIP);
        end
        // remainder is below twice BUCKETS here
        if (state_reg == FR_DIV) begin
            rem_reg <= diff[HB_W:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        q_valid    = 1'b0;
        case (state_reg)
            FR_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = FR_MUL;
                end
            end
            FR_MUL: begin
                state_next = FR_DIV;
            end
            FR_DIV: begin
                state_next = FR_PUSH;
            end
            FR_PUSH: begin
                q_valid = 1'b1;
                if (q_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    assign q_op     = op_reg;
    assign q_key    = key_reg;
    assign q_bucket = rem_fix[HB_W-1:0];
endmodule
`default_nettype wire

// File: hdl/cht_queue.sv
// Two-entry queue between front and back end.
// Depends on cht_pkg.
`default_nettype none
module cht_queue import cht_pkg::*; #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire logic [W-1:0] wr_data,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output logic [W-1:0]      rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// File: hdl/cht_back.sv
// Back end: bucket heads, node pool memories, free stack and chain walk.
// Depends on cht_pkg.
`default_nettype none
module cht_back import cht_pkg::*; #(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int HB_W       = $clog2(BUCKETS),
    parameter int N_W        = $clog2(POOL_NODES)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire logic [1:0]       q_op,
    input  wire logic [KEY_W-1:0] q_key,
    input  wire logic [HB_W-1:0]  q_bucket,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_status,
    output logic [BKT_W-1:0]      out_bucket
);
    // links carry N_W+1 bits; the top bit set means null
    localparam int L_W = N_W + 1;
    localparam logic [L_W-1:0] NIL      = {1'b1, {N_W{1'b0}}};
    localparam logic [L_W-1:0] POOL_CNT = L_W'(POOL_NODES);

    back_state_t     state_reg, state_next;
    logic [L_W-1:0]  heads_reg [BUCKETS];
    logic [BUCKETS-1:0] hvalid_reg;
    logic [KEY_W-1:0] keys_mem [POOL_NODES];
    logic [L_W-1:0]  links_mem [POOL_NODES];
    logic [N_W-1:0]  free_mem [POOL_NODES];
    logic [L_W-1:0]  free_cnt_reg, free_cnt_next;
    // free stack below this fill mark reads as its reset value
    logic [L_W-1:0]  init_reg, init_next;

    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [HB_W-1:0]  bkt_reg, bkt_next;
    logic [L_W-1:0]   cur_reg, cur_next, prev_reg, prev_next;
    logic [KEY_W-1:0] rkey_reg;
    logic [L_W-1:0]   rlink_reg;
    logic [N_W-1:0]   rfree_reg;
    logic [L_W-1:0]   head_val;
    logic [1:0]       st_reg, st_next;
    logic             ov_reg, ov_next;

    logic             hw_en;  logic [L_W-1:0] hw_data;
    logic             lw_en;  logic [N_W-1:0] lw_addr; logic [L_W-1:0] lw_data;
    logic             kw_en;
    logic             fw_en;  logic [N_W-1:0] fw_addr; logic [N_W-1:0] fw_data;
    logic [N_W-1:0]   rd_addr, fr_addr;
    logic             fr_init;

    assign head_val = hvalid_reg[bkt_reg] ? heads_reg[bkt_reg] : NIL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            hvalid_reg   <= '0;
            free_cnt_reg <= POOL_CNT;
            init_reg     <= POOL_CNT;
            ov_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            init_reg     <= init_next;
            ov_reg       <= ov_next;
            if (hw_en) hvalid_reg[bkt_reg] <= 1'b1;
        end
        if (hw_en) heads_reg[bkt_reg] <= hw_data;
        op_reg   <= op_next;
        key_reg  <= key_next;
        bkt_reg  <= bkt_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        st_reg   <= st_next;
    end

    always_ff @(posedge aclk) begin
        if (kw_en) keys_mem[lw_addr] <= key_reg;
        if (lw_en) links_mem[lw_addr] <= lw_data;
        if (fw_en) free_mem[fw_addr] <= fw_data;
        rkey_reg  <= keys_mem[rd_addr];
        rlink_reg <= links_mem[rd_addr];
        rfree_reg <= fr_init ? N_W'(POOL_NODES - 1) - fr_addr : free_mem[fr_addr];
    end

    always_comb begin
        state_next    = state_reg;
        free_cnt_next = free_cnt_reg;
        init_next     = init_reg;
        op_next = op_reg; key_next = key_reg; bkt_next = bkt_reg;
        cur_next = cur_reg; prev_next = prev_reg;
        st_next = st_reg; ov_next = ov_reg;
        q_ready = 1'b0;
        hw_en = 1'b0; hw_data = '0;
        lw_en = 1'b0; kw_en = 1'b0; lw_addr = '0; lw_data = '0;
        fw_en = 1'b0; fw_addr = '0; fw_data = '0;
        rd_addr = cur_reg[N_W-1:0];
        fr_addr = free_cnt_reg[N_W-1:0] - 1'b1;
        fr_init = (free_cnt_reg <= init_reg);
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_ready = !ov_reg || out_ready;
                if (q_valid && q_ready) begin
                    op_next = q_op; key_next = q_key; bkt_next = q_bucket;
                    state_next = BK_HEAD;
                end
            end
            BK_HEAD: begin
                prev_next = NIL;
                cur_next  = head_val;
                st_next   = ST_NOT_FOUND;
                if (op_reg == OP_INSERT) begin
                    if (free_cnt_reg == '0) begin
                        st_next = ST_FULL;
                        state_next = BK_DONE;
                    end else begin
                        state_next = BK_READ; // free stack top read in flight
                    end
                end else if (op_reg == OP_SEARCH || op_reg == OP_DELETE) begin
                    state_next = (head_val[N_W]) ? BK_DONE : BK_READ;
                end else begin
                    state_next = BK_DONE;
                end
            end
            BK_READ: begin
                if (op_reg == OP_INSERT) begin
                    // pop node, write key and link, push at head
                    lw_addr = rfree_reg;
                    kw_en = 1'b1; lw_en = 1'b1; lw_data = head_val;
                    hw_en = 1'b1; hw_data = {1'b0, rfree_reg};
                    free_cnt_next = free_cnt_reg - 1'b1;
                    if (init_reg > free_cnt_next) init_next = free_cnt_next;
                    st_next = ST_OK;
                    state_next = BK_DONE;
                end else begin
                    state_next = BK_CMP;
                end
            end
            BK_CMP: begin
                if (rkey_reg == key_reg) begin
                    st_next = ST_OK;
                    state_next = (op_reg == OP_DELETE) ? BK_UNLINK : BK_DONE;
                end else if (rlink_reg[N_W]) begin
                    state_next = BK_DONE;
                end else begin
                    prev_next = cur_reg;
                    cur_next = rlink_reg;
                    state_next = BK_READ;
                end
            end
            BK_UNLINK: begin
                if (prev_reg[N_W]) begin
                    hw_en = 1'b1; hw_data = rlink_reg;
                end else begin
                    lw_en = 1'b1; lw_addr = prev_reg[N_W-1:0]; lw_data = rlink_reg;
                end
                fw_en = 1'b1;
                fw_addr = free_cnt_reg[N_W-1:0];
                fw_data = cur_reg[N_W-1:0];
                free_cnt_next = free_cnt_reg + 1'b1;
                state_next = BK_DONE;
            end
            BK_DONE: begin
                if (!ov_reg || out_ready) begin
                    ov_next = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    logic [1:0]       ost_reg;
    logic [BKT_W-1:0] obkt_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == BK_DONE && (!ov_reg || out_ready)) begin
            ost_reg  <= st_reg;
            obkt_reg <= BKT_W'(bkt_reg);
        end
    end
    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_bucket = obkt_reg;
endmodule
`default_nettype wire

// File: hdl/chained_hash_table.sv
// Top level of the chained hash table: front end, queue, back end.
// Depends on cht_pkg, cht_front, cht_queue, cht_back.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | op[1:0], key[32:2], zero pad to 40 bits
//  m_axis  | out | status[1:0], bucket[5:2], zero pad to 8 bits
//
// The front end steps through accept, multiply, remainder and push for each
// item, the push waiting for queue space. The back end reads the bucket head,
// then compares each chain node visited; an insert pops a free node, a delete unlinks.
// A two-entry queue lets the front end reduce the next key during a walk.
// Synchronous active-low reset; the free stack reads its reset contents
// through a fill mark, so no clearing pass is needed.
`default_nettype none
module chained_hash_table import cht_pkg::*; #(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op[1:0], key[32:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status[1:0], bucket[5:2]
);
    localparam int HB_W = $clog2(BUCKETS);
    localparam int QW   = 2 + KEY_W + HB_W;

    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    logic [1:0]       f_op;
    logic [KEY_W-1:0] f_key;
    logic [HB_W-1:0]  f_bkt;
    logic [QW-1:0]    qb_data;
    logic [1:0]       o_status;
    logic [BKT_W-1:0] o_bucket;

    cht_front #(.BUCKETS(BUCKETS), .HB_W(HB_W)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[1:0]), .in_key(s_tdata[32:2]),
        .q_valid(fq_valid), .q_ready(fq_ready),
        .q_op(f_op), .q_key(f_key), .q_bucket(f_bkt)
    );

    cht_queue #(.W(QW)) u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data({f_bkt, f_key, f_op}),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    cht_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES), .HB_W(HB_W)) u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready),
        .q_op(qb_data[1:0]), .q_key(qb_data[KEY_W+1:2]),
        .q_bucket(qb_data[QW-1:KEY_W+2]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(o_status), .out_bucket(o_bucket)
    );

    assign m_tdata = {2'b00, o_bucket, o_status};
endmodule
`default_nettype wire
